[hw/rtl/wsfd_pkg.sv]
package wsfd_pkg;

	// parser phase codes
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// extended length bytes still to come after the first one
	localparam logic [2:0] EXT16_LEFT = 3'd1;
	localparam logic [2:0] EXT64_LEFT = 3'd7;

	// index of the last masking key byte
	localparam logic [1:0] KEY_LAST = 2'd3;

	// one result request
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_data;
		logic       last_of_frame;
		logic [3:0] frame_opcode;
		logic       frame_fin;
	} res_t;

endpackage

[hw/rtl/wsfd_ifs.sv]
// raw byte channel
interface wsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

// deframed result channel
interface wsfd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_data;
	logic       last_of_frame;
	logic [3:0] frame_opcode;
	logic       frame_fin;

	modport source (
		output valid, output payload_byte, output has_data, output last_of_frame,
		output frame_opcode, output frame_fin, input ready
	);
	modport sink (
		input valid, input payload_byte, input has_data, input last_of_frame,
		input frame_opcode, input frame_fin, output ready
	);
endinterface

[hw/rtl/wsfd_parse.sv]
module wsfd_parse
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	output logic       res_vld,
	output res_t       res
);

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  ext_cnt_q, ext_cnt_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [31:0] key_q, key_d;
	logic [63:0] remain_q, remain_d;
	logic [1:0]  key_idx_q, key_idx_d;
	logic [6:0]  len7;
	logic [7:0]  key_byte;
	logic [7:0]  data_byte;
	logic        last;

	assign len7 = byte_s1[6:0];

	// key byte for the current payload index, first key byte in the top bits
	always_comb begin
		unique case (key_idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		ext_cnt_d = ext_cnt_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		key_d     = key_q;
		remain_d  = remain_q;
		key_idx_d = key_idx_q;
		res_vld   = 1'b0;
		data_byte = 8'd0;
		last      = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				masked_d  = byte_s1[7];
				key_idx_d = 2'd0;
				key_d     = 32'd0;
				if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
					remain_d  = 64'd0;
					ext_cnt_d = (len7 == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
					phase_d   = PH_EXT;
				end else begin
					remain_d = {57'd0, len7};
					if (byte_s1[7]) begin
						phase_d = PH_KEY;
					end else if (len7 == 7'd0) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						last    = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXT: begin
				remain_d = {remain_q[55:0], byte_s1};
				if (ext_cnt_q != 3'd0) begin
					ext_cnt_d = ext_cnt_q - 3'd1;
				end else if (masked_q) begin
					key_idx_d = 2'd0;
					phase_d   = PH_KEY;
				end else begin
					key_idx_d = 2'd0;
					if ({remain_q[55:0], byte_s1} == 64'd0) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						last    = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				if (key_idx_q != KEY_LAST) begin
					key_idx_d = key_idx_q + 2'd1;
				end else begin
					key_idx_d = 2'd0;
					if (remain_q == 64'd0) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						last    = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				key_idx_d = key_idx_q + 2'd1;
				remain_d  = remain_q - 64'd1;
				last      = (remain_q == 64'd1);
				data_byte = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
				res_vld   = 1'b1;
				if (remain_q == 64'd1) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
		endcase
	end

	// result fields; opcode and fin only change on a byte that gives no result
	always_comb begin
		res.payload_byte  = data_byte;
		res.has_data      = (phase_q == PH_DATA);
		res.last_of_frame = last;
		res.frame_opcode  = opcode_q;
		res.frame_fin     = fin_q;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			ext_cnt_q <= 3'd0;
			fin_q     <= 1'b0;
			opcode_q  <= 4'd0;
			masked_q  <= 1'b0;
			key_q     <= 32'd0;
			remain_q  <= 64'd0;
			key_idx_q <= 2'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			ext_cnt_q <= ext_cnt_d;
			fin_q     <= fin_d;
			opcode_q  <= opcode_d;
			masked_q  <= masked_d;
			key_q     <= key_d;
			remain_q  <= remain_d;
			key_idx_q <= key_idx_d;
		end
	end

endmodule

[hw/rtl/wsfd_out.sv]
module wsfd_out
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	output logic       free,
	wsfd_res_if.source res_o
);

	logic valid_q;
	res_t res_q;

	// register can take a result when empty or being drained
	assign free = !valid_q || res_o.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign res_o.valid         = valid_q;
	assign res_o.payload_byte  = res_q.payload_byte;
	assign res_o.has_data      = res_q.has_data;
	assign res_o.last_of_frame = res_q.last_of_frame;
	assign res_o.frame_opcode  = res_q.frame_opcode;
	assign res_o.frame_fin     = res_q.frame_fin;

endmodule

[hw/rtl/websocket_frame_deframer_top.sv]
// channel | dir | payload                                              | request
// rx      | in  | byte_in[7:0]                                         | one stream byte
// res     | out | payload_byte, has_data, last_of_frame, frame_opcode, | one deframed byte
//         |     | frame_fin                                            | or empty frame
//
// one byte per clock sustained while res.ready stays high; a byte goes input register -> parser
// -> result register, and its result is driven onto res from the result register
// header, length and key bytes give no result, except the one ending an empty frame
// arst_n clears the parser to expect a new frame header
// a stalled result register holds the parser; a full input register then drops rx.ready
module websocket_frame_deframer_top
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	wsfd_byte_if.sink   rx,
	wsfd_res_if.source  res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	logic       res_vld;
	res_t       res_d;

	// the held byte moves on whenever the result register has room
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.byte_in;
		end
	end

	wsfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res_vld (res_vld),
		.res     (res_d)
	);

	wsfd_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_vld),
		.res    (res_d),
		.free   (out_free),
		.res_o  (res)
	);

endmodule

[sim/testbench.sv]
module testbench;
	import wsfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// how a stream byte's outcome is known: typed in, none at all, or from the parser copy
	typedef enum logic [1:0] {
		ROW_CALC  = 2'd0,
		ROW_QUIET = 2'd1,
		ROW_FIXED = 2'd2
	} row_kind_e;

	// how a frame length is encoded on the wire
	typedef enum logic [1:0] {
		FORM_MIN = 2'd0,
		FORM_16  = 2'd1,
		FORM_64  = 2'd2
	} len_form_e;

	typedef struct packed {
		row_kind_e kind;
		res_t      res;
	} tag_t;

	typedef struct packed {
		logic [7:0] b;
		row_kind_e  kind;
		res_t       res;
	} row_t;

	localparam int N_ROWS = 25;

	// directed stream: empty ping, reserved opcode with rsv bits, non-minimal 16-bit empty,
	// masked frame with a 64-bit length
	localparam row_t DIR_ROWS [N_ROWS] = '{
		{8'h89, ROW_QUIET, 15'h0},
		{8'h00, ROW_FIXED, {8'h00, 1'b0, 1'b1, 4'h9, 1'b1}},
		{8'h7F, ROW_QUIET, 15'h0},
		{8'h02, ROW_QUIET, 15'h0},
		{8'h00, ROW_FIXED, {8'h00, 1'b1, 1'b0, 4'hF, 1'b0}},
		{8'hFF, ROW_FIXED, {8'hFF, 1'b1, 1'b1, 4'hF, 1'b0}},
		{8'h82, ROW_QUIET, 15'h0},
		{8'h7E, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_FIXED, {8'h00, 1'b0, 1'b1, 4'h2, 1'b1}},
		{8'h0A, ROW_QUIET, 15'h0},
		{8'hFF, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h01, ROW_QUIET, 15'h0},
		{8'hA5, ROW_QUIET, 15'h0},
		{8'h5A, ROW_QUIET, 15'h0},
		{8'hFF, ROW_QUIET, 15'h0},
		{8'h00, ROW_QUIET, 15'h0},
		{8'h3C, ROW_CALC, 15'h0}
	};

	logic clk;
	logic arst_n;

	wsfd_byte_if rx_if ();
	wsfd_res_if  res_if ();

	websocket_frame_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// parser copy
	logic [2:0]  ph;
	logic [2:0]  ext_left;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [31:0] key;
	logic [63:0] remaining;
	logic [1:0]  key_idx;

	res_t deframed_due [$];
	tag_t byte_tags [$];

	int gap_pct;
	int stall_pct;
	int hold_left;
	int n_accepted;
	int n_results;
	int errors;
	int frames;
	int masked_frames;
	int ext_frames;

	// advance the parser copy by one stream byte; returns 1 when a result comes out
	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		bit hdr_done;
		bit emit;
		logic [7:0] kb;
		hdr_done = 1'b0;
		emit = 1'b0;
		kb = 8'h00;
		r = '0;
		case (ph)
			PH_HDR1: begin
				masked = b[7];
				key_idx = '0;
				key = '0;
				if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
					remaining = '0;
					ext_left = (b[6:0] == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
					ph = PH_EXT;
				end else begin
					remaining = 64'(b[6:0]);
					if (masked)
						ph = PH_KEY;
					else
						hdr_done = 1'b1;
				end
			end
			PH_EXT: begin
				remaining = {remaining[55:0], b};
				if (ext_left != 3'd0) begin
					ext_left = ext_left - 3'd1;
				end else if (masked) begin
					key_idx = '0;
					ph = PH_KEY;
				end else begin
					hdr_done = 1'b1;
				end
			end
			PH_KEY: begin
				key = {key[23:0], b};
				if (key_idx != KEY_LAST)
					key_idx = key_idx + 2'd1;
				else
					hdr_done = 1'b1;
			end
			PH_DATA: begin
				if (masked)
					kb = 8'(key >> (24 - 8 * int'(key_idx)));
				key_idx = key_idx + 2'd1;
				remaining = remaining - 64'd1;
				emit = 1'b1;
				r.payload_byte = b ^ kb;
				r.has_data = 1'b1;
				r.last_of_frame = (remaining == 64'd0);
				if (remaining == 64'd0)
					ph = PH_HDR0;
			end
			default: begin
				fin = b[7];
				opcode = b[3:0];
				ph = PH_HDR1;
			end
		endcase
		// header complete: an empty frame ends here with one empty result
		if (hdr_done) begin
			key_idx = '0;
			if (remaining == 64'd0) begin
				ph = PH_HDR0;
				emit = 1'b1;
				r.last_of_frame = 1'b1;
			end else begin
				ph = PH_DATA;
			end
		end
		r.frame_opcode = opcode;
		r.frame_fin = fin;
		return emit;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d results still due", deframed_due.size());
		$display("Mismatches found");
		$finish;
	end

	// result side: ready pattern, with a counted hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// accepted requests feed the parser copy; results are checked in order
	always @(posedge clk) begin
		res_t seen;
		res_t calc;
		res_t want;
		tag_t tag;
		bit   made;
		if (rx_if.valid && rx_if.ready) begin
			tag = (byte_tags.size() != 0) ? byte_tags.pop_front() : tag_t'(0);
			made = deframe_byte(rx_if.byte_in, calc);
			if (tag.kind == ROW_FIXED)
				deframed_due.push_back(tag.res);
			else if (tag.kind == ROW_CALC && made)
				deframed_due.push_back(calc);
			n_accepted++;
		end
		if (res_if.valid && res_if.ready) begin
			seen = {res_if.payload_byte, res_if.has_data, res_if.last_of_frame,
				res_if.frame_opcode, res_if.frame_fin};
			n_results++;
			if (deframed_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: byte %h has %b last %b op %h fin %b",
						seen.payload_byte, seen.has_data, seen.last_of_frame,
						seen.frame_opcode, seen.frame_fin);
			end else begin
				want = deframed_due.pop_front();
				if (seen !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("result %0d: expected byte %h has %b last %b op %h fin %b",
							n_results, want.payload_byte, want.has_data,
							want.last_of_frame, want.frame_opcode, want.frame_fin);
						$display("    actual byte %h has %b last %b op %h fin %b",
							seen.payload_byte, seen.has_data, seen.last_of_frame,
							seen.frame_opcode, seen.frame_fin);
					end
				end
			end
		end
	end

	// offer one stream byte, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input row_kind_e kind = ROW_CALC,
			input res_t fixed = '0);
		while ($urandom_range(99) < gap_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_tags.push_back({kind, fixed});
		rx_if.valid <= 1'b1;
		rx_if.byte_in <= b;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	// stop offering and wait until every due result has come
	task automatic drain();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (deframed_due.size() != 0);
	endtask

	// one frame: header, length, optional key, then n_bytes random payload bytes
	task automatic send_frame(input bit fin_b, input logic [3:0] op, input bit mask_b,
			input logic [63:0] len, input len_form_e form, input int n_bytes);
		logic [31:0] mkey;
		logic [6:0]  len7;
		int          n_ext;
		mkey = $urandom;
		if (form == FORM_64 || (form == FORM_MIN && len > 64'hFFFF)) begin
			len7 = LEN_EXT64;
			n_ext = 8;
		end else if (form == FORM_16 || len >= 64'd126) begin
			len7 = LEN_EXT16;
			n_ext = 2;
		end else begin
			len7 = len[6:0];
			n_ext = 0;
		end
		send_byte({fin_b, 3'($urandom), op});
		send_byte({mask_b, len7});
		for (int i = n_ext - 1; i >= 0; i--)
			send_byte(8'(len >> (8 * i)));
		if (mask_b)
			for (int i = 3; i >= 0; i--)
				send_byte(8'(mkey >> (8 * i)));
		for (int i = 0; i < n_bytes; i++)
			send_byte(8'($urandom));
		frames++;
		masked_frames += int'(mask_b);
		ext_frames += int'(n_ext != 0);
	endtask

	// well-formed frame with random content, mostly short
	task automatic random_frame();
		int          pick;
		logic [63:0] len;
		len_form_e   form;
		pick = $urandom_range(99);
		form = FORM_MIN;
		if (pick < 10)
			len = 64'd0;
		else if (pick < 70)
			len = 64'($urandom_range(10, 1));
		else if (pick < 90)
			len = 64'($urandom_range(125, 11));
		else if (pick < 95)
			len = 64'($urandom_range(300, 126));
		else begin
			len = 64'($urandom_range(20));
			form = pick[0] ? FORM_16 : FORM_64;
		end
		send_frame(1'($urandom_range(1)), 4'($urandom), $urandom_range(99) < 70, len, form,
			int'(len));
	endtask

	// stimulus
	initial begin
		ph = PH_HDR0;
		ext_left = '0;
		fin = 1'b0;
		opcode = '0;
		masked = 1'b0;
		key = '0;
		remaining = '0;
		key_idx = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		n_accepted = 0;
		n_results = 0;
		errors = 0;
		frames = 0;
		masked_frames = 0;
		ext_frames = 0;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.byte_in <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed stream
		for (int i = 0; i < N_ROWS; i++)
			send_byte(DIR_ROWS[i].b, DIR_ROWS[i].kind, DIR_ROWS[i].res);
		drain();

		// random frames under each idling pattern
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 60; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 60; end
				default: begin gap_pct = 12; stall_pct = 12; end
			endcase
			if (mode == 0) begin
				// long result hold-off while bytes keep coming, so the input backs up
				hold_left = 400;
				send_frame(1'b1, 4'h2, 1'b0, 64'd200, FORM_MIN, 200);
				drain();
			end
			while (n_accepted < N_ROWS + 350 * (mode + 1))
				random_frame();
			drain();
		end

		// largest 64-bit length with the top bit set; the frame never ends
		send_frame(1'b1, 4'h2, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, FORM_64, 30);
		drain();
		repeat (16) @(posedge clk);

		if (deframed_due.size() != 0) begin
			errors += deframed_due.size();
			$display("%0d results never arrived", deframed_due.size());
		end
		$display("%0d stream bytes in %0d frames (%0d masked, %0d with extended length)",
			n_accepted, frames + 4, masked_frames + 1, ext_frames + 2);
		$display("%0d deframed results checked, %0d errors", n_results, errors);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_ifs.sv
hw/rtl/wsfd_parse.sv
hw/rtl/wsfd_out.sv
hw/rtl/websocket_frame_deframer_top.sv
sim/testbench.sv
